FILE: sv/sdrb_pkg.sv
// ----------------------------------------------------------------------------
// sdrb_pkg
// shared types and codes for the spike delay ring buffer
// ----------------------------------------------------------------------------
package sdrb_pkg;

    localparam int unsigned NEURON_BITS = 16;
    localparam int unsigned DELAY_BITS  = 5;
    localparam int unsigned NIB_BITS    = 4;
    localparam int unsigned LANES_BITS  = NEURON_BITS * NIB_BITS;

    typedef logic [1:0]             t_kind;
    typedef logic [NEURON_BITS-1:0] t_spikes;
    typedef logic [DELAY_BITS-1:0]  t_delay;
    typedef logic [LANES_BITS-1:0]  t_lane_delays;

    localparam t_kind KIND_PUSH      = 2'd0;
    localparam t_kind KIND_READ      = 2'd1;
    localparam t_kind KIND_LANE_READ = 2'd2;
    localparam t_kind KIND_CLEAR     = 2'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // per-item read control carried beside the memory read
    typedef struct packed {
        t_spikes mask;
        logic    status;
    } t_rd_ctl;

endpackage

FILE: sv/sdrb_if.sv
// ----------------------------------------------------------------------------
// sdrb_in_if / sdrb_out_if
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface sdrb_in_if;
    import sdrb_pkg::*;

    logic         valid;
    logic         ready;
    t_kind        kind;
    t_spikes      spike_bits;
    t_delay       delay;
    t_lane_delays lane_delays;

    modport source (output valid, kind, spike_bits, delay, lane_delays, input ready);
    modport sink   (input valid, kind, spike_bits, delay, lane_delays, output ready);
endinterface

interface sdrb_out_if;
    import sdrb_pkg::*;

    logic    valid;
    logic    ready;
    t_spikes delayed_spikes;
    logic    status;

    modport source (output valid, delayed_spikes, status, input ready);
    modport sink   (input valid, delayed_spikes, status, output ready);
endinterface

FILE: sv/spike_delay_ring_buffer.sv
// ----------------------------------------------------------------------------
// spike_delay_ring_buffer
// Axonal delay line for a group of neurons. Each neuron owns a one-bit
// column memory of MAX_DELAY rows; a push writes every column at the write
// pointer, a read sends each column its own row address (the same one for a
// single-delay read, one per lane for a per-lane read). The block takes one
// item every cycle while the sink takes results: each column does one write
// or one read per cycle, so pushes, clears and reads stream back to back. A
// read result goes through the memory read register, then the output register.
// Rows not yet written since reset or a clear read as zero through the fill
// count, so a clear just resets the write pointer and count: no clearing pass.
// ----------------------------------------------------------------------------
module spike_delay_ring_buffer #(
    parameter int unsigned NEURONS   = 16,
    parameter int unsigned MAX_DELAY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdrb_in_if.sink    i_in,
    sdrb_out_if.source o_out
);
    import sdrb_pkg::*;

    localparam int unsigned AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

    logic                       w_accept;
    logic                       w_wr_en;
    logic [AW-1:0]              w_wr_addr;
    logic                       w_rd_en;
    logic [NEURONS-1:0][AW-1:0] w_rd_addr;
    t_rd_ctl                    w_rd_ctl;
    logic [NEURONS-1:0]         w_rd_bits;
    logic                       w_take;
    logic                       w_s1_move;
    t_spikes                    w_s1_data;

    logic    r_s1_valid;
    t_rd_ctl r_s1_ctl;

    assign w_s1_move  = r_s1_valid && w_take;
    assign i_in.ready = !r_s1_valid || w_s1_move;
    assign w_accept   = i_in.valid && i_in.ready;

    sdrb_ring_ctl #(
        .NEURONS   (NEURONS),
        .MAX_DELAY (MAX_DELAY),
        .AW        (AW)
    ) u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_kind        (i_in.kind),
        .i_delay       (i_in.delay),
        .i_lane_delays (i_in.lane_delays),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .o_rd_ctl      (w_rd_ctl)
    );

    for (genvar g = 0; g < NEURONS; g++) begin : g_lane
        sdrb_lane_mem #(
            .DEPTH (MAX_DELAY),
            .AW    (AW)
        ) u_mem (
            .i_clk     (i_clk),
            .i_wr_en   (w_wr_en),
            .i_wr_addr (w_wr_addr),
            .i_wr_bit  (i_in.spike_bits[g]),
            .i_rd_en   (w_rd_en),
            .i_rd_addr (w_rd_addr[g]),
            .o_rd_bit  (w_rd_bits[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_rd_en) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_s1_ctl <= w_rd_ctl;
        end
    end

    assign w_s1_data = NEURON_BITS'(w_rd_bits) & r_s1_ctl.mask;

    sdrb_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_s1_valid),
        .i_data   (w_s1_data),
        .i_status (r_s1_ctl.status),
        .o_take   (w_take),
        .o_out    (o_out)
    );

    // full pipeline with a stalled sink must not take an item
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("item accepted with both stages full");

    // an accepted read lands in the memory read stage
    a_read_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.kind == KIND_READ || i_in.kind == KIND_LANE_READ))
        |=> r_s1_valid)
        else $error("read item lost at memory stage");

    // a result leaving the memory stage shows up at the output
    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move |=> o_out.valid)
        else $error("result lost between stages");

    // pushes and clears never produce a result
    a_no_result_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.kind == KIND_PUSH || i_in.kind == KIND_CLEAR)
         && !r_s1_valid) |=> !r_s1_valid)
        else $error("result created by push or clear");

endmodule

FILE: sv/sdrb_lane_mem.sv
// ----------------------------------------------------------------------------
// sdrb_lane_mem
// one neuron's column of the ring: one write and one registered read a cycle
// ----------------------------------------------------------------------------
module sdrb_lane_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_bit,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_bit
);

    logic r_mem [DEPTH];
    logic r_rd_bit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_bit <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_bit = r_rd_bit;

endmodule

FILE: sv/sdrb_ring_ctl.sv
// ----------------------------------------------------------------------------
// sdrb_ring_ctl
// write pointer, fill count, per-lane read addresses and history masks
// ----------------------------------------------------------------------------
module sdrb_ring_ctl #(
    parameter int unsigned NEURONS   = 16,
    parameter int unsigned MAX_DELAY = 16,
    parameter int unsigned AW        = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  sdrb_pkg::t_kind             i_kind,
    input  sdrb_pkg::t_delay            i_delay,
    input  sdrb_pkg::t_lane_delays      i_lane_delays,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output logic                        o_rd_en,
    output logic [NEURONS-1:0][AW-1:0]  o_rd_addr,
    output sdrb_pkg::t_rd_ctl           o_rd_ctl
);
    import sdrb_pkg::*;

    localparam int unsigned FW = $clog2(MAX_DELAY + 1);

    logic [AW-1:0]                r_write_slot;
    logic [FW-1:0]                r_fill_count;
    logic [NEURONS-1:0][DELAY_BITS-1:0] w_d;
    logic [NEURONS-1:0]           w_bad;
    logic [DELAY_BITS:0]          w_ws6;
    logic [DELAY_BITS:0]          w_d6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;
            r_fill_count <= '0;
        end else if (i_accept && i_kind == KIND_CLEAR) begin
            r_write_slot <= '0;
            r_fill_count <= '0;
        end else if (i_accept && i_kind == KIND_PUSH) begin
            if (r_write_slot == AW'(MAX_DELAY - 1)) begin
                r_write_slot <= '0;
            end else begin
                r_write_slot <= r_write_slot + 1'b1;
            end
            if (r_fill_count != FW'(MAX_DELAY)) begin
                r_fill_count <= r_fill_count + 1'b1;
            end
        end
    end

    assign o_wr_en   = i_accept && (i_kind == KIND_PUSH);
    assign o_wr_addr = r_write_slot;
    assign o_rd_en   = i_accept && (i_kind == KIND_READ || i_kind == KIND_LANE_READ);

    always_comb begin
        o_rd_ctl = '0;
        w_ws6    = (DELAY_BITS + 1)'(r_write_slot);
        w_d6     = '0;
        for (int i = 0; i < NEURONS; i++) begin
            if (i_kind == KIND_READ) begin
                w_d[i] = i_delay;
            end else begin
                w_d[i] = DELAY_BITS'(i_lane_delays[NIB_BITS*i +: NIB_BITS]) + 1'b1;
            end
            w_bad[i] = (w_d[i] == '0) || (w_d[i] > DELAY_BITS'(MAX_DELAY));
            w_d6     = {1'b0, w_d[i]};
            if (w_bad[i]) begin
                o_rd_addr[i] = '0;
            end else if (w_ws6 >= w_d6) begin
                o_rd_addr[i] = AW'(w_ws6 - w_d6);
            end else begin
                o_rd_addr[i] = AW'(w_ws6 + (DELAY_BITS + 1)'(MAX_DELAY) - w_d6);
            end
            o_rd_ctl.mask[i] = !w_bad[i] && (w_d[i] <= DELAY_BITS'(r_fill_count));
        end
        o_rd_ctl.status = (|w_bad) ? STATUS_RANGE : STATUS_OK;
    end

endmodule

FILE: sv/sdrb_out_stage.sv
// ----------------------------------------------------------------------------
// sdrb_out_stage
// output register holding one result item until the sink takes it
// ----------------------------------------------------------------------------
module sdrb_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sdrb_pkg::t_spikes i_data,
    input  logic              i_status,
    output logic              o_take,
    sdrb_out_if.source        o_out
);
    import sdrb_pkg::*;

    logic    r_valid;
    t_spikes r_data;
    logic    r_status;

    assign o_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_load) begin
            r_data   <= i_data;
            r_status <= i_status;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.delayed_spikes = r_data;
    assign o_out.status         = r_status;

endmodule

FILE: test/tb_spike_delay_ring_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spike_delay_ring_buffer
// Self-checking bench for the spike delay ring buffer. A shadow copy of the
// ring (rows, write slot, fill count) is updated on every accepted command
// and turns each single-delay or per-lane read into an expected result. Each
// result item is compared field by field with the oldest expected one.
// Directed cases cover empty history, out-of-range delays, wrap and clear.
// Random traffic follows, with idle bursts on both channels. One long
// receiver hold makes the block back up and stall its input. A last
// stretch runs without any idling.
// ----------------------------------------------------------------------------
module tb_spike_delay_ring_buffer;
    import sdrb_pkg::*;

    localparam int unsigned NEURONS    = 16;
    localparam int unsigned MAX_DELAY  = 16;
    localparam int unsigned LONG_HOLD  = 200;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam t_spikes     LANE_MASK  = t_spikes'((32'd1 << NEURONS) - 1);

    typedef struct {
        t_spikes spikes;
        logic    status;
    } t_read_result;

    logic clk = 1'b0;
    logic rst_n;

    sdrb_in_if  in_if ();
    sdrb_out_if out_if ();

    spike_delay_ring_buffer #(
        .NEURONS   (NEURONS),
        .MAX_DELAY (MAX_DELAY)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 clk = ~clk;

    // shadow ring state
    t_spikes      ring_rows [MAX_DELAY];
    int unsigned  ring_wr_slot;
    int unsigned  ring_fill;
    t_read_result expected_reads [$];

    int unsigned  n_errors    = 0;
    int unsigned  idle_cycles = 0;
    bit           src_idle    = 1'b1;
    bit           sink_idle   = 1'b1;
    bit           hold_request = 1'b0;

    function automatic void ring_clear();
        for (int i = 0; i < MAX_DELAY; i++) ring_rows[i] = '0;
        ring_wr_slot = 0;
        ring_fill    = 0;
    endfunction

    function automatic int unsigned row_at(int unsigned d);
        return (ring_wr_slot + MAX_DELAY - d) % MAX_DELAY;
    endfunction

    function automatic void apply_command(t_kind k, t_spikes bits, t_delay dly,
                                          t_lane_delays lanes);
        t_read_result r;
        int unsigned  d;
        r.spikes = '0;
        r.status = STATUS_OK;
        case (k)
            KIND_PUSH: begin
                ring_rows[ring_wr_slot] = bits & LANE_MASK;
                ring_wr_slot = (ring_wr_slot + 1) % MAX_DELAY;
                if (ring_fill < MAX_DELAY) ring_fill++;
            end
            KIND_CLEAR: begin
                ring_clear();
            end
            KIND_READ: begin
                if (dly < 1 || dly > MAX_DELAY) begin
                    r.status = STATUS_RANGE;
                end else if (dly <= ring_fill) begin
                    r.spikes = ring_rows[row_at(dly)] & LANE_MASK;
                end
                expected_reads.push_back(r);
            end
            default: begin
                for (int i = 0; i < NEURONS; i++) begin
                    d = lanes[NIB_BITS*i +: NIB_BITS] + 1;
                    if (d > MAX_DELAY) begin
                        r.status = STATUS_RANGE;
                    end else if (d <= ring_fill) begin
                        r.spikes[i] = ring_rows[row_at(d)][i];
                    end
                end
                expected_reads.push_back(r);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // prediction on accepted commands, then checking of accepted results
    always @(posedge clk) begin
        t_read_result want;
        if (rst_n) begin
            if (in_if.valid && in_if.ready)
                apply_command(in_if.kind, in_if.spike_bits, in_if.delay, in_if.lane_delays);
            if (out_if.valid && out_if.ready) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch("unexpected result", out_if.delayed_spikes, '0);
                end else begin
                    want = expected_reads.pop_front();
                    if (out_if.delayed_spikes !== want.spikes)
                        report_mismatch("delayed_spikes", out_if.delayed_spikes, want.spikes);
                    if (out_if.status !== want.status)
                        report_mismatch("status", 16'(out_if.status), 16'(want.status));
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_spike_delay_ring_buffer: errors");
                $finish;
            end
        end
    end

    // result receiver
    initial begin
        forever begin
            if (hold_request) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_command(t_kind k, t_spikes bits, t_delay dly, t_lane_delays lanes);
        if (src_idle && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.kind        <= k;
        in_if.spike_bits  <= bits;
        in_if.delay       <= dly;
        in_if.lane_delays <= lanes;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    task automatic send_random_command(int unsigned push_pct);
        int unsigned r;
        t_kind       k;
        t_delay      dly;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            k = KIND_PUSH;
        else if (r < push_pct + (97 - push_pct) / 2)
            k = KIND_READ;
        else if (r < 97)
            k = KIND_LANE_READ;
        else
            k = KIND_CLEAR;
        if ($urandom_range(0, 9) == 0)
            dly = t_delay'($urandom_range(0, 31));
        else
            dly = t_delay'($urandom_range(1, MAX_DELAY));
        send_command(k, t_spikes'($urandom), dly, {$urandom, $urandom});
    endtask

    task automatic test_history_and_range();
        send_command(KIND_READ, '1, 5'd1, '0);
        send_command(KIND_READ, '0, 5'd0, '0);
        send_command(KIND_READ, '0, 5'd17, '0);
        send_command(KIND_READ, '0, 5'd31, '1);
        send_command(KIND_LANE_READ, '0, 5'd0, '1);
        send_command(KIND_PUSH, 16'hFFFF, 5'd0, '0);
        send_command(KIND_PUSH, 16'h0000, 5'd31, '1);
        send_command(KIND_PUSH, 16'hA5A5, 5'd0, '0);
        send_command(KIND_PUSH, 16'h5A5A, 5'd0, '0);
        send_command(KIND_READ, '0, 5'd1, '0);
        send_command(KIND_READ, '0, 5'd4, '0);
        send_command(KIND_READ, '0, 5'd5, '0);
        send_command(KIND_READ, '0, 5'd16, '0);
    endtask

    task automatic test_lane_reads();
        send_command(KIND_LANE_READ, '0, 5'd0, 64'h0123_4567_89AB_CDEF);
        send_command(KIND_LANE_READ, '1, 5'd0, 64'h3210_3210_3210_3210);
        send_command(KIND_LANE_READ, '0, 5'd0, 64'h0000_0000_0000_0000);
    endtask

    task automatic test_clear();
        send_command(KIND_CLEAR, '1, 5'd1, '1);
        send_command(KIND_READ, '0, 5'd1, '0);
        send_command(KIND_LANE_READ, '0, 5'd0, '0);
        send_command(KIND_PUSH, 16'h8000, 5'd0, '0);
        send_command(KIND_PUSH, 16'h0001, 5'd0, '0);
        send_command(KIND_READ, '0, 5'd2, '0);
    endtask

    task automatic test_random_traffic(int unsigned n);
        repeat (n) send_random_command(40);
    endtask

    task automatic test_backpressure(int unsigned n);
        src_idle     = 1'b0;
        hold_request = 1'b1;
        repeat (n) send_random_command(20);
        src_idle = 1'b1;
    endtask

    task automatic test_streaming(int unsigned n);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (n) send_random_command(40);
    endtask

    initial begin
        ring_clear();
        rst_n             <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.kind        <= KIND_PUSH;
        in_if.spike_bits  <= '0;
        in_if.delay       <= '0;
        in_if.lane_delays <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_history_and_range();
        test_lane_reads();
        test_clear();
        test_random_traffic(650);
        test_backpressure(60);
        test_streaming(170);
        in_if.valid <= 1'b0;

        while (expected_reads.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_errors == 0)
            $display("tb_spike_delay_ring_buffer: clean");
        else
            $display("tb_spike_delay_ring_buffer: errors");
        $finish;
    end

endmodule

FILE: files.f
sv/sdrb_pkg.sv
sv/sdrb_if.sv
sv/sdrb_lane_mem.sv
sv/sdrb_ring_ctl.sv
sv/sdrb_out_stage.sv
sv/spike_delay_ring_buffer.sv
test/tb_spike_delay_ring_buffer.sv
